// ----- src/spq_pkg.sv -----
// Shared types, codes and defaults for the stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    // Default sizes for the top-level parameters.
    localparam int DEF_CAPACITY       = 16;
    localparam int DEF_VALUE_WIDTH    = 16;
    localparam int DEF_PRIORITY_WIDTH = 3;

    // Fixed widths of the result fields.
    localparam int STATUS_WIDTH = 2;
    localparam int OCC_WIDTH    = 5;

    // Operation carried in the request's tuser bit.
    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } t_kind;

    // Result status carried in the result's tuser bits.
    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Per-cycle command broadcast to every cell of the row.
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

// ----- src/spq_cell.sv -----
// One slot of the sorted row: holds an entry and shifts or inserts with its neighbors.
`timescale 1ns / 1ps

module spq_cell #(
    parameter int VALUE_WIDTH    = spq_pkg::DEF_VALUE_WIDTH,
    parameter int PRIORITY_WIDTH = spq_pkg::DEF_PRIORITY_WIDTH
) (
    input  logic                      i_clk,
    input  spq_pkg::t_cell_ctl        i_ctl,
    input  logic                      i_occupied,
    input  logic [VALUE_WIDTH-1:0]    i_new_value,
    input  logic [PRIORITY_WIDTH-1:0] i_new_prio,
    input  logic                      i_left_ge,
    input  logic [VALUE_WIDTH-1:0]    i_left_value,
    input  logic [PRIORITY_WIDTH-1:0] i_left_prio,
    input  logic [VALUE_WIDTH-1:0]    i_right_value,
    input  logic [PRIORITY_WIDTH-1:0] i_right_prio,
    output logic                      o_ge,
    output logic [VALUE_WIDTH-1:0]    o_value,
    output logic [PRIORITY_WIDTH-1:0] o_prio
);

    logic [VALUE_WIDTH-1:0]    r_value;
    logic [PRIORITY_WIDTH-1:0] r_prio;
    logic [VALUE_WIDTH-1:0]    n_value;
    logic [PRIORITY_WIDTH-1:0] n_prio;

    // The entry stays ahead of a new one of equal or lower priority.
    assign o_ge    = i_occupied && (r_prio >= i_new_prio);
    assign o_value = r_value;
    assign o_prio  = r_prio;

    always_comb begin
        n_value = r_value;
        n_prio  = r_prio;
        if (i_ctl.push) begin
            if (o_ge) begin
                n_value = r_value;
                n_prio  = r_prio;
            end else if (i_left_ge) begin
                // First slot that loses the compare takes the new entry.
                n_value = i_new_value;
                n_prio  = i_new_prio;
            end else begin
                n_value = i_left_value;
                n_prio  = i_left_prio;
            end
        end else if (i_ctl.pop) begin
            n_value = i_right_value;
            n_prio  = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

endmodule

// ----- src/stable_priority_queue.sv -----
// Top level of the stable priority queue: request/result channels and the cell row.
`timescale 1ns / 1ps

// The block keeps up to CAPACITY entries sorted by priority in a row of cells,
// head at cell zero. Every cell compares its own priority with that of an
// incoming push in parallel and, together with its left neighbor's result,
// decides whether to hold, take the new entry or take its left neighbor's
// entry. A pop shifts every cell one place toward the head.
// Requests arrive on the slave channel: tuser holds the kind (0 push, 1 pop)
// and tdata holds the value in the low bits and the priority above it.
// Each request gives exactly one result on the master channel: tuser holds
// the status (ok, pop on empty, push on full) and tdata holds the removed
// value, its priority and the occupancy after the request.
// Results are registered, valid in the cycle after acceptance. One request is
// taken every cycle, limited only by the single-entry output register: a new
// request is taken whenever that register is empty or drains in the same cycle.
// If the receiver stalls, the result waits in the output register and the
// slave channel stops accepting once it is full.
// Reset empties the queue and the output register; cell contents are left
// as they are, since only occupied cells are ever read.

module stable_priority_queue #(
    parameter int CAPACITY       = spq_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH    = spq_pkg::DEF_VALUE_WIDTH,
    parameter int PRIORITY_WIDTH = spq_pkg::DEF_PRIORITY_WIDTH,
    localparam int IN_DW  = ((VALUE_WIDTH + PRIORITY_WIDTH + 7) / 8) * 8,
    localparam int OUT_DW = ((VALUE_WIDTH + PRIORITY_WIDTH + spq_pkg::OCC_WIDTH + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [IN_DW-1:0]                 i_s_tdata,  // value, priority_req
    input  logic                             i_s_tuser,  // kind
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [OUT_DW-1:0]                o_m_tdata,  // out_value, out_priority, occupancy
    output logic [spq_pkg::STATUS_WIDTH-1:0] o_m_tuser   // status
);

    localparam int CW = $clog2(CAPACITY + 1);

    // Request fields.
    logic                      w_accept;
    logic                      w_is_pop;
    logic [VALUE_WIDTH-1:0]    w_in_value;
    logic [PRIORITY_WIDTH-1:0] w_in_prio;
    logic                      w_full;
    logic                      w_empty;
    spq_pkg::t_cell_ctl        w_ctl;

    // Occupancy counter.
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW+spq_pkg::OCC_WIDTH-1:0] w_count_ext;

    // Output register.
    logic                             r_out_valid;
    spq_pkg::t_status                 r_out_status;
    logic [VALUE_WIDTH-1:0]           r_out_value;
    logic [PRIORITY_WIDTH-1:0]        r_out_prio;
    logic [spq_pkg::OCC_WIDTH-1:0]    r_out_occ;
    spq_pkg::t_status                 n_out_status;
    logic [VALUE_WIDTH-1:0]           n_out_value;
    logic [PRIORITY_WIDTH-1:0]        n_out_prio;

    // Cell row outputs.
    logic [VALUE_WIDTH-1:0]    w_value [CAPACITY];
    logic [PRIORITY_WIDTH-1:0] w_prio  [CAPACITY];
    logic                      w_ge    [CAPACITY];

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_is_pop   = (spq_pkg::t_kind'(i_s_tuser) == spq_pkg::KIND_POP);
    assign w_in_value = i_s_tdata[VALUE_WIDTH-1:0];
    assign w_in_prio  = i_s_tdata[VALUE_WIDTH+PRIORITY_WIDTH-1:VALUE_WIDTH];
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_empty    = (r_count == '0);

    // Full pushes and empty pops leave the row untouched.
    assign w_ctl.push = w_accept && !w_is_pop && !w_full;
    assign w_ctl.pop  = w_accept && w_is_pop && !w_empty;

    always_comb begin
        n_count      = r_count;
        n_out_status = spq_pkg::ST_OK;
        n_out_value  = '0;
        n_out_prio   = '0;
        if (w_is_pop) begin
            if (w_empty) begin
                n_out_status = spq_pkg::ST_EMPTY;
            end else begin
                n_out_value = w_value[0];
                n_out_prio  = w_prio[0];
                n_count     = r_count - CW'(1);
            end
        end else begin
            if (w_full) begin
                n_out_status = spq_pkg::ST_FULL;
            end else begin
                n_count = r_count + CW'(1);
            end
        end
    end

    // Occupancy is reported modulo the field width.
    assign w_count_ext = {{spq_pkg::OCC_WIDTH{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_status <= n_out_status;
            r_out_value  <= n_out_value;
            r_out_prio   <= n_out_prio;
            r_out_occ    <= w_count_ext[spq_pkg::OCC_WIDTH-1:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = OUT_DW'({r_out_occ, r_out_prio, r_out_value});

    // The row of cells. Cell zero is the head; the left neighbor of cell zero
    // is treated as winning its compare so a push can land at the head.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        logic                      w_left_ge;
        logic [VALUE_WIDTH-1:0]    w_left_value;
        logic [PRIORITY_WIDTH-1:0] w_left_prio;
        logic [VALUE_WIDTH-1:0]    w_right_value;
        logic [PRIORITY_WIDTH-1:0] w_right_prio;

        if (i == 0) begin : g_head
            assign w_left_ge    = 1'b1;
            assign w_left_value = w_in_value;
            assign w_left_prio  = w_in_prio;
        end else begin : g_body
            assign w_left_ge    = w_ge[i-1];
            assign w_left_value = w_value[i-1];
            assign w_left_prio  = w_prio[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign w_right_value = w_value[i];
            assign w_right_prio  = w_prio[i];
        end else begin : g_inner
            assign w_right_value = w_value[i+1];
            assign w_right_prio  = w_prio[i+1];
        end

        spq_cell #(
            .VALUE_WIDTH    (VALUE_WIDTH),
            .PRIORITY_WIDTH (PRIORITY_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_occupied    (IDX < r_count),
            .i_new_value   (w_in_value),
            .i_new_prio    (w_in_prio),
            .i_left_ge     (w_left_ge),
            .i_left_value  (w_left_value),
            .i_left_prio   (w_left_prio),
            .i_right_value (w_right_value),
            .i_right_prio  (w_right_prio),
            .o_ge          (w_ge[i]),
            .o_value       (w_value[i]),
            .o_prio        (w_prio[i])
        );
    end

    // The count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("queue count above capacity");

    // A successful push grows the queue by exactly one entry.
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.push |=> r_count == $past(r_count) + CW'(1))
        else $error("push did not advance the count");

    // A pop on an empty queue reports empty and returns a zero value.
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_pop && w_empty) |=>
            (o_m_tvalid && o_m_tuser == spq_pkg::ST_EMPTY && r_out_value == '0))
        else $error("empty pop reported wrongly");

    // The two head entries stay in priority order.
    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> (w_prio[0] >= w_prio[1]))
        else $error("head entries out of order");

endmodule
